>>> rtl/mcb_pkg.sv
// shared types, codes and morse pattern tables for the morse code beacon
package mcb_pkg;

	localparam int BUF_DEPTH_DEF = 512;
	localparam int NUM_REGS      = 6;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_START  = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		CODE_NONE      = 3'd0,
		CODE_DOT       = 3'd1,
		CODE_DASH      = 3'd2,
		CODE_SYM_GAP   = 3'd3,
		CODE_CHAR_GAP  = 3'd4,
		CODE_WORD_GAP  = 3'd5,
		CODE_SENT_GAP  = 3'd6,
		CODE_SPARE     = 3'd7
	} code_t;

	typedef enum logic [2:0] {
		REG_DOT      = 3'd0,
		REG_DASH     = 3'd1,
		REG_SYM_GAP  = 3'd2,
		REG_CHAR_GAP = 3'd3,
		REG_WORD_GAP = 3'd4,
		REG_SENT_GAP = 3'd5
	} reg_idx_t;

	localparam logic [7:0] REG_RESET [NUM_REGS] = '{8'd1, 8'd3, 8'd1, 8'd3, 8'd7, 8'd7};

	typedef enum logic [1:0] {
		CLS_ALNUM = 2'd0,
		CLS_WORD  = 2'd1,
		CLS_SENT  = 2'd2,
		CLS_OTHER = 2'd3
	} char_cls_t;

	typedef enum logic [1:0] {
		PUSH_CHAR_GAP = 2'd0,
		PUSH_STEP     = 2'd1,
		PUSH_WORD     = 2'd2,
		PUSH_SENT     = 2'd3
	} push_sel_t;

	// symbol count and dash mask, first symbol in bit 0
	typedef struct packed {
		logic [2:0] len;
		logic [4:0] dash;
	} pat_t;

	localparam pat_t LETTER_PATS [26] = '{
		{3'd2, 5'b00010}, {3'd4, 5'b00001}, {3'd4, 5'b00101}, {3'd3, 5'b00001},
		{3'd1, 5'b00000}, {3'd4, 5'b00100}, {3'd3, 5'b00011}, {3'd4, 5'b00000},
		{3'd2, 5'b00000}, {3'd4, 5'b01110}, {3'd3, 5'b00101}, {3'd4, 5'b00010},
		{3'd2, 5'b00011}, {3'd2, 5'b00001}, {3'd3, 5'b00111}, {3'd4, 5'b00110},
		{3'd4, 5'b01011}, {3'd3, 5'b00010}, {3'd3, 5'b00000}, {3'd1, 5'b00001},
		{3'd3, 5'b00100}, {3'd4, 5'b01000}, {3'd3, 5'b00110}, {3'd4, 5'b01001},
		{3'd4, 5'b01101}, {3'd4, 5'b00011}
	};

	localparam pat_t DIGIT_PATS [10] = '{
		{3'd5, 5'b11111}, {3'd5, 5'b11110}, {3'd5, 5'b11100}, {3'd5, 5'b11000},
		{3'd5, 5'b10000}, {3'd5, 5'b00000}, {3'd5, 5'b00001}, {3'd5, 5'b00011},
		{3'd5, 5'b00111}, {3'd5, 5'b01111}
	};

	typedef struct packed {
		logic      latch_item;
		logic      do_clear;
		logic      do_start;
		logic      tick_dec;
		logic      tick_end;
		logic      rd_issue;
		logic      tick_apply;
		logic      push_en;
		push_sel_t push_sel;
		logic      step_inc;
		logic      set_alnum;
		logic      clr_alnum;
		logic      out_load;
	} dp_cmd_t;

	typedef struct packed {
		op_t       op;
		char_cls_t cls;
		logic      last_alnum;
		logic      step_last;
		logic      busy;
		logic      ticks_zero;
		logic      at_end;
	} dp_sts_t;

endpackage

>>> rtl/morse_code_beacon.sv
// top level of the morse code beacon: controller, datapath and config port
//
//  channel  | signals                                   | direction | transfer
//  item     | item_valid item_stall operation char_code | in        | valid & !stall
//           | repeat_mode                               |           |
//  result   | result_valid result_stall led_on encoding | out       | valid & !stall
//           | repeating overflow                        |           |
//  cfg      | cfg_valid cfg_ready cfg_index cfg_data    | in        | valid & ready
//
// clear, start, other appends and ticks that play no entry step through the idle,
// execute and done states; a tick that plays an entry adds an apply state for the
// registered buffer read. an alphanumeric append adds a symbol step per symbol and
// symbol gap, set by the single buffer write port writing one entry per cycle.
// asynchronous active-low reset clears all control state; the buffer needs no clearing.
// the next transaction is accepted while a result waits; a result still stalled when
// the next one is ready holds the block in its final step until taken.
module morse_code_beacon import mcb_pkg::*; #(
	parameter int BUFFER_DEPTH = BUF_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [1:0] operation,
	input  logic [7:0] char_code,
	input  logic       repeat_mode,
	output logic       result_valid,
	input  logic       result_stall,
	output logic       led_on,
	output logic       encoding,
	output logic       repeating,
	output logic       overflow,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// always ready; writes belong to times with no transaction in flight
	assign cfg_ready = 1'b1;

	mcb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.sts          (sts),
		.cmd          (cmd)
	);

	mcb_datapath #(
		.BUFFER_DEPTH (BUFFER_DEPTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (operation),
		.char_code   (char_code),
		.repeat_mode (repeat_mode),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.led_on      (led_on),
		.encoding    (encoding),
		.repeating   (repeating),
		.overflow    (overflow)
	);

endmodule

>>> rtl/mcb_datapath.sv
// datapath: item latch, code buffer, play counters, config registers, result register
module mcb_datapath import mcb_pkg::*; #(
	parameter int BUFFER_DEPTH = BUF_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  dp_cmd_t    cmd,
	output dp_sts_t    sts,
	input  logic [1:0] operation,
	input  logic [7:0] char_code,
	input  logic       repeat_mode,
	input  logic       cfg_valid,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	output logic       led_on,
	output logic       encoding,
	output logic       repeating,
	output logic       overflow
);

	localparam int CW = $clog2(BUFFER_DEPTH + 1);
	localparam int AW = $clog2(BUFFER_DEPTH);

	logic [1:0]    op_q;
	logic [7:0]    char_q;
	logic          rep_q;
	logic [3:0]    step_q;

	logic [2:0]    mem [BUFFER_DEPTH];
	logic [2:0]    rd_data_q;

	logic [CW-1:0] entry_count_q;
	logic [CW-1:0] play_index_q;
	logic [7:0]    ticks_q;
	logic          led_q;
	logic          busy_q;
	logic          repeat_q;
	logic          alnum_q;
	logic          overflow_q;
	logic [7:0]    regs_q [NUM_REGS];

	logic [7:0]    up;
	logic          is_letter;
	logic          is_digit;
	logic          is_space;
	logic          is_sent;
	char_cls_t     cls;
	pat_t          pat;
	code_t         step_code;
	code_t         push_code;
	logic          full;
	logic [7:0]    dur;

	// character classification
	always_comb begin
		up        = (char_q >= 8'h61 && char_q <= 8'h7a) ? char_q - 8'd32 : char_q;
		is_letter = (up >= 8'h41 && up <= 8'h5a);
		is_digit  = (char_q >= 8'h30 && char_q <= 8'h39);
		is_space  = (char_q == 8'h20) || (char_q == 8'h09) || (char_q == 8'h0a) ||
			(char_q == 8'h0b) || (char_q == 8'h0c);
		is_sent   = (char_q == 8'h2e) || (char_q == 8'h21) || (char_q == 8'h3f);
		priority if (is_letter || is_digit) begin
			cls = CLS_ALNUM;
		end else if (is_space) begin
			cls = CLS_WORD;
		end else if (is_sent) begin
			cls = CLS_SENT;
		end else begin
			cls = CLS_OTHER;
		end
		if (is_letter) begin
			pat = LETTER_PATS[5'(up - 8'h41)];
		end else if (is_digit) begin
			pat = DIGIT_PATS[4'(char_q - 8'h30)];
		end else begin
			pat = '0;
		end
	end

	// even steps are symbols, odd steps are symbol gaps
	always_comb begin
		if (step_q[0]) begin
			step_code = CODE_SYM_GAP;
		end else if (pat.dash[step_q[3:1]]) begin
			step_code = CODE_DASH;
		end else begin
			step_code = CODE_DOT;
		end
		unique case (cmd.push_sel)
			PUSH_CHAR_GAP: push_code = CODE_CHAR_GAP;
			PUSH_STEP:     push_code = step_code;
			PUSH_WORD:     push_code = CODE_WORD_GAP;
			PUSH_SENT:     push_code = CODE_SENT_GAP;
			default:       push_code = CODE_NONE;
		endcase
	end

	assign full = (entry_count_q == CW'(BUFFER_DEPTH));

	always_comb begin
		unique case (code_t'(rd_data_q))
			CODE_DOT:      dur = regs_q[REG_DOT];
			CODE_DASH:     dur = regs_q[REG_DASH];
			CODE_SYM_GAP:  dur = regs_q[REG_SYM_GAP];
			CODE_CHAR_GAP: dur = regs_q[REG_CHAR_GAP];
			CODE_WORD_GAP: dur = regs_q[REG_WORD_GAP];
			CODE_SENT_GAP: dur = regs_q[REG_SENT_GAP];
			default:       dur = 8'd0;
		endcase
	end

	always_comb begin
		sts.op         = op_t'(op_q);
		sts.cls        = cls;
		sts.last_alnum = alnum_q;
		sts.step_last  = (step_q == {pat.len, 1'b0} - 4'd2);
		sts.busy       = busy_q;
		sts.ticks_zero = (ticks_q == 8'd0);
		sts.at_end     = (play_index_q >= entry_count_q);
	end

	// item latch and step counter
	always_ff @(posedge clk) begin
		if (cmd.latch_item) begin
			op_q   <= operation;
			char_q <= char_code;
			rep_q  <= repeat_mode;
			step_q <= 4'd0;
		end else if (cmd.step_inc) begin
			step_q <= step_q + 4'd1;
		end
	end

	// code buffer
	always_ff @(posedge clk) begin
		if (cmd.push_en && !full) begin
			mem[entry_count_q[AW-1:0]] <= push_code;
		end
		if (cmd.rd_issue) begin
			rd_data_q <= mem[play_index_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			play_index_q  <= '0;
			ticks_q       <= 8'd0;
			led_q         <= 1'b0;
			busy_q        <= 1'b0;
			repeat_q      <= 1'b0;
			alnum_q       <= 1'b0;
			overflow_q    <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= REG_RESET[i];
			end
		end else begin
			if (cfg_valid && cfg_index < 3'(NUM_REGS)) begin
				regs_q[cfg_index] <= cfg_data;
			end
			if (cmd.do_clear) begin
				entry_count_q <= '0;
				play_index_q  <= '0;
				ticks_q       <= 8'd0;
				led_q         <= 1'b0;
				busy_q        <= 1'b0;
				alnum_q       <= 1'b0;
				overflow_q    <= 1'b0;
			end
			if (cmd.do_start) begin
				play_index_q <= '0;
				ticks_q      <= 8'd0;
				led_q        <= 1'b0;
				busy_q       <= 1'b1;
				repeat_q     <= rep_q;
			end
			if (cmd.tick_dec) begin
				ticks_q <= ticks_q - 8'd1;
			end
			if (cmd.tick_end) begin
				led_q        <= 1'b0;
				play_index_q <= '0;
				ticks_q      <= 8'd0;
				if (!repeat_q) begin
					busy_q <= 1'b0;
				end
			end
			if (cmd.tick_apply) begin
				led_q        <= !led_q;
				ticks_q      <= (dur != 8'd0) ? dur - 8'd1 : 8'd0;
				play_index_q <= play_index_q + CW'(1);
			end
			if (cmd.push_en) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					entry_count_q <= entry_count_q + CW'(1);
				end
			end
			if (cmd.set_alnum) begin
				alnum_q <= 1'b1;
			end else if (cmd.clr_alnum) begin
				alnum_q <= 1'b0;
			end
		end
	end

	// result register, held while the result waits
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			led_on    <= led_q;
			encoding  <= busy_q;
			repeating <= repeat_q;
			overflow  <= overflow_q;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count_q <= CW'(BUFFER_DEPTH))
		else $error("entry count beyond buffer depth");

	a_play_bound: assert property (@(posedge clk) disable iff (!arst_n)
		play_index_q <= entry_count_q)
		else $error("play index past message end");

	a_full_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push_en && full && !cmd.do_clear) |=> overflow_q)
		else $error("dropped entry without overflow flag");

	a_apply_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_apply |-> (play_index_q < entry_count_q) && busy_q)
		else $error("entry played outside the message");

endmodule

>>> rtl/mcb_ctrl.sv
// controller: item sequencing, append expansion steps and result handshake
module mcb_ctrl import mcb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	output logic    result_valid,
	input  logic    result_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SYM,
		S_TICK_APPLY,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   result_valid_q;

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.latch_item = 1'b1;
					state_d        = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_DONE;
				unique case (sts.op)
					OP_CLEAR: cmd.do_clear = 1'b1;
					OP_START: cmd.do_start = 1'b1;
					OP_APPEND: begin
						unique case (sts.cls)
							CLS_ALNUM: begin
								// character gap only between adjacent alphanumerics
								if (sts.last_alnum) begin
									cmd.push_en  = 1'b1;
									cmd.push_sel = PUSH_CHAR_GAP;
								end
								state_d = S_SYM;
							end
							CLS_WORD: begin
								cmd.push_en   = 1'b1;
								cmd.push_sel  = PUSH_WORD;
								cmd.clr_alnum = 1'b1;
							end
							CLS_SENT: begin
								cmd.push_en   = 1'b1;
								cmd.push_sel  = PUSH_SENT;
								cmd.clr_alnum = 1'b1;
							end
							default: cmd.clr_alnum = 1'b1;
						endcase
					end
					OP_TICK: begin
						priority if (!sts.busy) begin
							state_d = S_DONE;
						end else if (!sts.ticks_zero) begin
							cmd.tick_dec = 1'b1;
						end else if (sts.at_end) begin
							cmd.tick_end = 1'b1;
						end else begin
							cmd.rd_issue = 1'b1;
							state_d      = S_TICK_APPLY;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_SYM: begin
				cmd.push_en  = 1'b1;
				cmd.push_sel = PUSH_STEP;
				cmd.step_inc = 1'b1;
				if (sts.step_last) begin
					cmd.set_alnum = 1'b1;
					state_d       = S_DONE;
				end
			end
			S_TICK_APPLY: begin
				cmd.tick_apply = 1'b1;
				state_d        = S_DONE;
			end
			S_DONE: begin
				// wait until the result register is free
				if (!(result_valid_q && result_stall)) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(result_valid_q && result_stall))
		else $error("result overwritten while waiting");

	a_latch_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.latch_item |-> state_q == S_IDLE)
		else $error("item latched while busy");

	a_apply_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick_apply |-> $past(cmd.rd_issue))
		else $error("entry applied without buffer read");

endmodule

>>> bench/morse_code_beacon_tb.sv
// self-checking testbench for the morse code beacon with its own behavioral predictor
module morse_code_beacon_tb;
	import mcb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MSG_DEPTH      = BUF_DEPTH_DEF;
	localparam int SETTLE_CYCLES  = 16;
	localparam int HOLD_CYCLES    = 300;
	localparam int CYCLE_LIMIT    = 1_000_000;
	localparam int RANDOM_ITEMS   = 450;
	localparam int MAX_REPORTS    = 10;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_CR    = 8'h0d;

	typedef struct packed {
		logic led;
		logic enc;
		logic rep;
		logic ovf;
	} beacon_out_t;

	logic       clk          = 1'b0;
	logic       arst_n       = 1'b0;
	logic       item_valid   = 1'b0;
	logic       item_stall;
	logic [1:0] operation    = OP_CLEAR;
	logic [7:0] char_code    = 8'h00;
	logic       repeat_mode  = 1'b0;
	logic       result_valid;
	logic       result_stall = 1'b0;
	logic       led_on;
	logic       encoding;
	logic       repeating;
	logic       overflow;
	logic       cfg_valid    = 1'b0;
	logic       cfg_ready;
	logic [2:0] cfg_index    = REG_DOT;
	logic [7:0] cfg_data     = 8'h00;

	morse_code_beacon u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.operation    (operation),
		.char_code    (char_code),
		.repeat_mode  (repeat_mode),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.led_on       (led_on),
		.encoding     (encoding),
		.repeating    (repeating),
		.overflow     (overflow),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	code_t       msg_codes [MSG_DEPTH];
	int unsigned msg_len;
	int unsigned play_pos;
	logic [7:0]  pred_ticks;
	logic        lamp;
	logic        playing;
	logic        looping;
	logic        after_alnum;
	logic        dropped;
	logic [7:0]  dur_reg [NUM_REGS];

	string letter_morse [26] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
		"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
		"..-", "...-", ".--", "-..-", "-.--", "--.."
	};
	string digit_morse [10] = '{
		"-----", ".----", "..---", "...--", "....-",
		".....", "-....", "--...", "---..", "----."
	};

	beacon_out_t expected_states [$];
	int          fail_count   = 0;
	int          items_sent   = 0;
	int          cycle_count  = 0;
	bit          idle_enable  = 1'b1;
	int          hold_request = 0;
	int          hold_left    = 0;

	function automatic void add_code(code_t c);
		if (msg_len < MSG_DEPTH) begin
			msg_codes[msg_len] = c;
			msg_len++;
		end else begin
			dropped = 1'b1;
		end
	endfunction

	function automatic void emit_pattern(string p);
		for (int i = 0; i < p.len(); i++) begin
			if (p[i] == "-")
				add_code(CODE_DASH);
			else
				add_code(CODE_DOT);
			if (i + 1 < p.len())
				add_code(CODE_SYM_GAP);
		end
	endfunction

	function automatic void add_char(logic [7:0] c);
		logic [7:0] up;
		up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
		if (up >= "A" && up <= "Z") begin
			if (after_alnum)
				add_code(CODE_CHAR_GAP);
			emit_pattern(letter_morse[int'(up - "A")]);
			after_alnum = 1'b1;
		end else if (c >= "0" && c <= "9") begin
			if (after_alnum)
				add_code(CODE_CHAR_GAP);
			emit_pattern(digit_morse[int'(c - "0")]);
			after_alnum = 1'b1;
		end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF ||
				c == CH_VT || c == CH_FF) begin
			add_code(CODE_WORD_GAP);
			after_alnum = 1'b0;
		end else if (c == "." || c == "!" || c == "?") begin
			add_code(CODE_SENT_GAP);
			after_alnum = 1'b0;
		end else begin
			after_alnum = 1'b0;
		end
	endfunction

	function automatic void advance_tick();
		logic [7:0] dur;
		if (!playing)
			return;
		if (pred_ticks != 8'd0) begin
			pred_ticks--;
		end else if (play_pos >= msg_len) begin
			lamp       = 1'b0;
			play_pos   = 0;
			pred_ticks = 8'd0;
			if (!looping)
				playing = 1'b0;
		end else begin
			dur        = dur_reg[int'(msg_codes[play_pos]) - 1];
			lamp       = !lamp;
			pred_ticks = (dur == 8'd0) ? 8'd0 : dur - 8'd1;
			play_pos++;
		end
	endfunction

	function automatic beacon_out_t beacon_step(op_t op, logic [7:0] ch, logic rep);
		case (op)
			OP_CLEAR: begin
				msg_len     = 0;
				play_pos    = 0;
				pred_ticks  = 8'd0;
				lamp        = 1'b0;
				playing     = 1'b0;
				after_alnum = 1'b0;
				dropped     = 1'b0;
			end
			OP_APPEND: add_char(ch);
			OP_START: begin
				play_pos   = 0;
				pred_ticks = 8'd0;
				lamp       = 1'b0;
				playing    = 1'b1;
				looping    = rep;
			end
			default: advance_tick();
		endcase
		return '{lamp, playing, looping, dropped};
	endfunction

	// one transaction on the item channel; returns on the accepting edge
	task automatic send_item(op_t op, logic [7:0] ch, logic rep);
		while (idle_enable && $urandom_range(99) < 29) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid  <= 1'b1;
		operation   <= op;
		char_code   <= ch;
		repeat_mode <= rep;
		do
			@(posedge clk);
		while (item_stall);
		expected_states.push_back(beacon_step(op, ch, rep));
		items_sent++;
	endtask

	task automatic clear_msg();
		send_item(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	task automatic start_play(logic rep);
		send_item(OP_START, 8'($urandom_range(255)), rep);
	endtask

	task automatic tick_once();
		send_item(OP_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	task automatic append_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(OP_APPEND, s[i], 1'($urandom_range(1)));
	endtask

	task automatic play_until_idle(int cap);
		int n;
		n = 0;
		while (playing && n < cap) begin
			tick_once();
			n++;
		end
		tick_once();
	endtask

	// drain every outstanding result, then leave the block alone for a while
	task automatic settle();
		item_valid <= 1'b0;
		while (expected_states.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_durations(logic [7:0] dot, logic [7:0] dash, logic [7:0] sym,
			logic [7:0] chr, logic [7:0] word, logic [7:0] sent);
		logic [7:0] vals [NUM_REGS];
		reg_idx_t   idx;
		vals = '{dot, dash, sym, chr, word, sent};
		settle();
		idx = idx.first();
		repeat (NUM_REGS) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= vals[int'(idx)];
			do
				@(posedge clk);
			while (!cfg_ready);
			dur_reg[int'(idx)] = vals[int'(idx)];
			idx = idx.next();
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_char();
		int unsigned r;
		logic [7:0]  ws [5];
		r  = $urandom_range(99);
		ws = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF};
		if (r < 20)
			return 8'("A" + $urandom_range(25));
		else if (r < 35)
			return 8'("a" + $urandom_range(25));
		else if (r < 55)
			return 8'("0" + $urandom_range(9));
		else if (r < 68)
			return ws[$urandom_range(4)];
		else if (r < 78) begin
			r = $urandom_range(2);
			return (r == 0) ? "." : (r == 1) ? "!" : "?";
		end
		return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] pick_duration();
		if ($urandom_range(19) == 0)
			return 8'($urandom_range(1, 255));
		return 8'($urandom_range(1, 3));
	endfunction

	// every character class at reset durations, boundary codes included
	task automatic test_char_classes();
		clear_msg();
		tick_once();
		append_text("Az@90");
		send_item(OP_APPEND, CH_SPACE, 1'b0);
		send_item(OP_APPEND, CH_TAB, 1'b1);
		send_item(OP_APPEND, CH_LF, 1'b0);
		send_item(OP_APPEND, CH_VT, 1'b1);
		send_item(OP_APPEND, CH_FF, 1'b0);
		append_text("E");
		send_item(OP_APPEND, CH_CR, 1'b0);
		append_text("T.!?`/:[{");
		send_item(OP_APPEND, 8'h00, 1'b0);
		send_item(OP_APPEND, 8'hff, 1'b1);
		start_play(1'b0);
		play_until_idle(400);
		// an empty message ends on its first tick
		clear_msg();
		start_play(1'b0);
		tick_once();
		tick_once();
	endtask

	task automatic test_duration_extremes();
		load_durations(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
		clear_msg();
		append_text("AE. ");
		start_play(1'b1);
		repeat (30) tick_once();
		append_text("T");
		repeat (10) tick_once();
		start_play(1'b0);
		repeat (3) tick_once();
		// clear keeps the repeat setting
		clear_msg();
		tick_once();

		load_durations(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
		clear_msg();
		append_text("E");
		start_play(1'b0);
		play_until_idle(300);

		// zero-length durations still last one tick
		load_durations(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		clear_msg();
		append_text("AE. ");
		start_play(1'b1);
		repeat (20) tick_once();
		clear_msg();

		load_durations(8'd2, 8'd5, 8'd1, 8'd4, 8'd9, 8'd13);
		clear_msg();
		append_text("I4 N?");
		start_play(1'b0);
		play_until_idle(400);
	endtask

	task automatic test_overflow();
		load_durations(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
		clear_msg();
		repeat (52) append_text("0");
		append_text("E .");
		start_play(1'b0);
		repeat (40) tick_once();
		append_text("A");
		clear_msg();
		append_text("E");
		start_play(1'b0);
		play_until_idle(20);
	endtask

	// receiver holds off while the sender keeps offering, so the input backs up
	task automatic test_backpressure();
		hold_request = 1;
		clear_msg();
		append_text("SOS 73");
		start_play(1'b1);
		repeat (30) tick_once();
		clear_msg();
	endtask

	task automatic test_random_traffic();
		int base;
		int done;
		int seq;
		int n;
		int cap;
		logic rep;
		base = items_sent;
		seq  = 0;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			idle_enable = !(done >= 120 && done < 320);
			if (seq % 8 == 0)
				load_durations(pick_duration(), pick_duration(), pick_duration(),
					pick_duration(), pick_duration(), pick_duration());
			seq++;
			if ($urandom_range(99) < 85) begin
				if ($urandom_range(9) < 8)
					clear_msg();
				repeat ($urandom_range(1, 5))
					send_item(OP_APPEND, pick_char(), 1'($urandom_range(1)));
				rep = ($urandom_range(3) == 0);
				start_play(rep);
				cap = rep ? $urandom_range(10, 80) : 400;
				n   = 0;
				while (playing && n < cap) begin
					if ($urandom_range(19) == 0)
						send_item(OP_APPEND, pick_char(), 1'($urandom_range(1)));
					else if ($urandom_range(49) == 0)
						start_play(1'($urandom_range(1)));
					else
						tick_once();
					n++;
				end
			end else begin
				repeat ($urandom_range(1, 6))
					send_item(op_t'($urandom_range(3)), 8'($urandom_range(255)),
						1'($urandom_range(1)));
			end
			done = items_sent - base;
		end
		idle_enable = 1'b1;
	endtask

	// result side: random stalls plus the long hold-off on request
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= idle_enable && ($urandom_range(99) < 29);
		end
	end

	always @(posedge clk) begin
		beacon_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_states.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display({"unexpected result transaction: ",
						"led %0b encoding %0b repeating %0b overflow %0b"},
						led_on, encoding, repeating, overflow);
			end else begin
				want = expected_states.pop_front();
				if (led_on !== want.led || encoding !== want.enc ||
						repeating !== want.rep || overflow !== want.ovf) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display({"mismatch: led %0b/%0b encoding %0b/%0b ",
							"repeating %0b/%0b overflow %0b/%0b (exp/act)"},
							want.led, led_on, want.enc, encoding, want.rep, repeating,
							want.ovf, overflow);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("morse_code_beacon_tb NOT OK");
			$finish;
		end
	end

	initial begin
		msg_len     = 0;
		play_pos    = 0;
		pred_ticks  = 8'd0;
		lamp        = 1'b0;
		playing     = 1'b0;
		looping     = 1'b0;
		after_alnum = 1'b0;
		dropped     = 1'b0;
		dur_reg     = REG_RESET;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_char_classes();
		test_duration_extremes();
		test_overflow();
		test_backpressure();
		test_random_traffic();

		item_valid <= 1'b0;
		while (expected_states.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && expected_states.size() == 0)
			$display("morse_code_beacon_tb OK");
		else
			$display("morse_code_beacon_tb NOT OK");
		$finish;
	end

endmodule
